>>> rtl/umep_pkg.sv
// Package: shared types, constants and helpers of the USB-MIDI event packetizer.
`default_nettype none

package umep_pkg;

    localparam int STORE_BYTES_DEFAULT = 64;
    localparam int MAX_STORE_WORDS     = 16;

    localparam logic [6:0] MAX_PACKET_BYTES_RESET = 7'd64;
    // Rounded message sizes at or above this all compare the same way.
    localparam logic [7:0] NEED_SAT = 8'd128;

    localparam logic [7:0] SYSEX_START_BYTE = 8'hF0;
    localparam logic [7:0] SYSEX_END_BYTE   = 8'hF7;

    // USB-MIDI code index numbers for SysEx words
    localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
    localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

    typedef enum logic [1:0] {
        CMD_SHORT       = 2'd0,
        CMD_SYSEX_START = 2'd1,
        CMD_SYSEX_BYTE  = 2'd2,
        CMD_FLUSH       = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [3:0]  device;
        logic [3:0]  cable;
        logic [7:0]  status_byte;
        logic [7:0]  data_first;
        logic [7:0]  data_second;
        logic [15:0] sysex_length;
        logic [7:0]  payload_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] packet_word;
        logic [3:0]  out_device;
        logic        last_word;
    } out_t;

    // Store op from the front part to the store controller.
    typedef struct packed {
        logic        flush;   // emit pending words unconditionally
        logic        chk;     // emit first if fill + need reaches the packet size
        logic [7:0]  need;    // rounded message size in bytes, saturated
        logic [3:0]  dev;     // device for any packet this op emits
        logic [1:0]  nwords;  // words to place, 0..2
        logic [31:0] word0;
        logic [31:0] word1;
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EMIT,
        BK_PLACE
    } bk_state_t;

    function automatic logic [3:0] sysex_end_code(input logic [1:0] nbytes);
        logic [3:0] code;
        case (nbytes)
            2'd1:    code = CIN_SYSEX_END1;
            2'd2:    code = CIN_SYSEX_END2;
            2'd3:    code = CIN_SYSEX_END3;
            default: code = CIN_SYSEX_CONT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> rtl/umep_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module umep_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/umep_front.sv
// Front part: classifies input beats and frames SysEx into event words.
`default_nettype none

module umep_front
    import umep_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire in_t  item,
    output logic      op_valid,
    output op_t       op
);

    logic [16:0] sysex_left_reg, sysex_left_next;
    logic [23:0] chunk_reg, chunk_next;
    logic [1:0]  chunk_cnt_reg, chunk_cnt_next;
    logic [3:0]  sysex_cable_reg, sysex_cable_next;
    logic [3:0]  last_device_reg, last_device_next;

    // payload byte path
    logic [23:0] chunk1, chunk2, chunk_f;
    logic [2:0]  cnt1;
    logic [1:0]  cnt2, cnt_f;
    logic        chunk_full;
    logic [16:0] left1;
    logic        end_now;
    logic [31:0] word_cont, word_end;
    // sysex start path
    logic [16:0] len_round;
    logic [16:0] msg_bytes;

    always_comb
    begin
        chunk1     = chunk_reg | (24'(item.payload_byte) << {chunk_cnt_reg, 3'b000});
        cnt1       = 3'(chunk_cnt_reg) + 3'd1;
        chunk_full = (cnt1 == 3'd3);
        chunk2     = chunk_full ? 24'd0 : chunk1;
        cnt2       = chunk_full ? 2'd0 : cnt1[1:0];
        left1      = sysex_left_reg - 17'd1;
        end_now    = (left1 == 17'd1);
        chunk_f    = chunk2 | (24'(SYSEX_END_BYTE) << {cnt2, 3'b000});
        cnt_f      = cnt2 + 2'd1;
        word_cont  = {chunk1, sysex_cable_reg, CIN_SYSEX_CONT};
        word_end   = {chunk_f, sysex_cable_reg, sysex_end_code(cnt_f)};

        len_round = 17'(item.sysex_length) + 17'd5;
        msg_bytes = {len_round[16:2], 2'b00};

        sysex_left_next  = sysex_left_reg;
        chunk_next       = chunk_reg;
        chunk_cnt_next   = chunk_cnt_reg;
        sysex_cable_next = sysex_cable_reg;
        last_device_next = last_device_reg;

        op_valid  = 1'b0;
        op.flush  = 1'b0;
        op.chk    = 1'b0;
        op.need   = 8'd4;
        op.dev    = item.device;
        op.nwords = 2'd0;
        op.word0  = word_cont;
        op.word1  = word_end;

        case (item.cmd)
            CMD_SHORT:
            begin
                last_device_next = item.device;
                op_valid  = 1'b1;
                op.chk    = 1'b1;
                op.nwords = 2'd1;
                op.word0  = {item.data_second, item.data_first, item.status_byte,
                             item.cable, item.status_byte[7:4]};
            end
            CMD_SYSEX_START:
            begin
                // zero length start is dropped without touching state
                if (item.sysex_length != 16'd0)
                begin
                    last_device_next = item.device;
                    sysex_cable_next = item.cable;
                    sysex_left_next  = 17'(item.sysex_length) + 17'd1;
                    chunk_next       = 24'(SYSEX_START_BYTE);
                    chunk_cnt_next   = 2'd1;
                    op_valid = 1'b1;
                    op.chk   = 1'b1;
                    op.need  = (msg_bytes >= 17'(NEED_SAT)) ? NEED_SAT : msg_bytes[7:0];
                end
            end
            CMD_SYSEX_BYTE:
            begin
                op.dev = last_device_reg;
                // stray bytes outside a sysex are ignored
                if (sysex_left_reg >= 17'd2)
                begin
                    if (end_now)
                    begin
                        sysex_left_next = 17'd0;
                        chunk_next      = 24'd0;
                        chunk_cnt_next  = 2'd0;
                        op_valid        = 1'b1;
                        if (chunk_full)
                        begin
                            op.nwords = 2'd2;
                        end
                        else
                        begin
                            op.nwords = 2'd1;
                            op.word0  = word_end;
                        end
                    end
                    else
                    begin
                        sysex_left_next = left1;
                        chunk_next      = chunk2;
                        chunk_cnt_next  = cnt2;
                        if (chunk_full)
                        begin
                            op_valid  = 1'b1;
                            op.nwords = 2'd1;
                        end
                    end
                end
            end
            CMD_FLUSH:
            begin
                op_valid = 1'b1;
                op.flush = 1'b1;
            end
            default:
            begin
                op_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sysex_left_reg  <= '0;
            chunk_reg       <= '0;
            chunk_cnt_reg   <= '0;
            sysex_cable_reg <= '0;
            last_device_reg <= '0;
        end
        else if (accept)
        begin
            sysex_left_reg  <= sysex_left_next;
            chunk_reg       <= chunk_next;
            chunk_cnt_reg   <= chunk_cnt_next;
            sysex_cable_reg <= sysex_cable_next;
            last_device_reg <= last_device_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/umep_opq.sv
// Two-entry queue of work orders between the front part and the store controller.
`default_nettype none

module umep_opq
    import umep_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire op_t  wr_op,
    output logic      full,
    input  wire logic rd_en,
    output logic      empty,
    output op_t       rd_op
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rd_op = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

`default_nettype wire

>>> rtl/umep_back.sv
// Back part: packet store control, packet emission and the result queue.
`default_nettype none

module umep_back
    import umep_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [6:0] max_packet_bytes,
    input  wire logic       op_valid,
    input  wire op_t        op,
    output logic            op_done,
    output out_t            result,
    output logic            empty,
    input  wire logic       pop
);

    localparam int STORE_WORDS = ((STORE_BYTES / 4) < MAX_STORE_WORDS) ?
                                 (STORE_BYTES / 4) : MAX_STORE_WORDS;
    localparam int AW = $clog2(STORE_WORDS);
    localparam int FW = $clog2(STORE_WORDS + 1);

    bk_state_t   state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [3:0]    em_dev_reg, em_dev_next;
    logic          wi_reg, wi_next;

    logic          rd_pend_reg;
    logic [3:0]    pend_dev_reg;
    logic          pend_last_reg;

    out_t          res_reg [2];
    logic          res_wr_ptr_reg;
    logic          res_rd_ptr_reg;
    logic [1:0]    res_cnt_reg;

    logic          pop_fire;
    logic          issue;
    logic          rd_en;
    logic          rd_last;
    logic          we;
    logic [31:0]   wdata;
    logic [31:0]   rdata;
    logic [8:0]    need_sum;
    logic          emit_req;

    assign pop_fire = pop && (res_cnt_reg != 2'd0);
    assign empty    = (res_cnt_reg == 2'd0);
    assign result   = res_reg[res_rd_ptr_reg];

    // room check counts the read already in flight
    assign issue    = (3'(res_cnt_reg) + 3'(rd_pend_reg) - 3'(pop_fire)) < 3'd2;
    assign rd_last  = (rd_idx_reg == AW'(fill_reg - FW'(1)));
    assign need_sum = 9'({fill_reg, 2'b00}) + 9'(op.need);
    assign emit_req = op.flush || (op.chk && (need_sum >= 9'(max_packet_bytes)));
    assign wdata    = wi_reg ? op.word1 : op.word0;

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        rd_idx_next = rd_idx_reg;
        em_dev_next = em_dev_reg;
        wi_next     = wi_reg;
        op_done     = 1'b0;
        rd_en       = 1'b0;
        we          = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (op_valid)
                begin
                    wi_next = 1'b0;
                    if (emit_req && (fill_reg != '0))
                    begin
                        state_next  = BK_EMIT;
                        rd_idx_next = '0;
                        em_dev_next = op.dev;
                    end
                    else if (op.nwords != 2'd0)
                    begin
                        if (emit_req)
                        begin
                            fill_next = '0;
                        end
                        state_next = BK_PLACE;
                    end
                    else
                    begin
                        op_done = 1'b1;
                    end
                end
            end
            BK_EMIT:
            begin
                if (issue)
                begin
                    rd_en       = 1'b1;
                    rd_idx_next = rd_idx_reg + AW'(1);
                    if (rd_last)
                    begin
                        fill_next = '0;
                        if ({1'b0, wi_reg} < op.nwords)
                        begin
                            state_next = BK_PLACE;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                            op_done    = 1'b1;
                        end
                    end
                end
            end
            BK_PLACE:
            begin
                if (fill_reg == FW'(STORE_WORDS))
                begin
                    // store full: send it out before this word goes in
                    state_next  = BK_EMIT;
                    rd_idx_next = '0;
                    em_dev_next = op.dev;
                end
                else
                begin
                    we        = 1'b1;
                    fill_next = fill_reg + FW'(1);
                    if (2'(wi_reg) + 2'd1 == op.nwords)
                    begin
                        state_next = BK_IDLE;
                        op_done    = 1'b1;
                    end
                    else
                    begin
                        wi_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    umep_ram #(
        .WIDTH (32),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= BK_IDLE;
            fill_reg    <= '0;
            rd_idx_reg  <= '0;
            em_dev_reg  <= '0;
            wi_reg      <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_idx_reg  <= rd_idx_next;
            em_dev_reg  <= em_dev_next;
            wi_reg      <= wi_next;
            rd_pend_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_dev_reg  <= em_dev_reg;
            pend_last_reg <= rd_last;
        end
        if (rd_pend_reg)
        begin
            res_reg[res_wr_ptr_reg] <= '{packet_word: rdata,
                                         out_device:  pend_dev_reg,
                                         last_word:   pend_last_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            if (rd_pend_reg)
            begin
                res_wr_ptr_reg <= ~res_wr_ptr_reg;
            end
            if (pop_fire)
            begin
                res_rd_ptr_reg <= ~res_rd_ptr_reg;
            end
            res_cnt_reg <= res_cnt_reg + 2'(rd_pend_reg) - 2'(pop_fire);
        end
    end

endmodule

`default_nettype wire

>>> rtl/usb_midi_event_packetizer.sv
// Top level of the USB-MIDI event packetizer.
//
// Input side is a queue: drive an item and push; the beat is taken when full is low.
// Commands: short message, SysEx start (with payload length), one SysEx payload
// byte, flush. The front part frames SysEx into F0 ... F7 chunks of three bytes
// and turns each beat combinationally into at most one store op.
// A two-entry op queue decouples it from the store controller, which keeps up
// to STORE_BYTES/4 (at most 16) words in a RAM and emits them as a packet.
// Result side is a queue too: while empty is low the oldest result word sits on
// result; pop takes it. last_word marks the final word of each packet.
// Throughput: a beat that places a word passes the store controller's decide
// and write steps; a packet drains at one word per cycle while pop stays high,
// through a two-entry result queue behind the RAM's registered read port.
// A packet's first word passes the op queue, emit state, RAM read and result queue.
// A stalled result side stops the drain; the op queue then fills and full rises.
// Reset clears all control state and max_packet_bytes to 64; store contents
// are not cleared, the fill count makes stale entries unreachable.
// cfg_we writes max_packet_bytes into a register, meant for idle periods.
`default_nettype none

module usb_midi_event_packetizer
    import umep_pkg::*;
#(
    parameter int STORE_BYTES = STORE_BYTES_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire in_t        item,
    output logic            empty,
    input  wire logic       pop,
    output out_t            result,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata
);

    logic [6:0] max_packet_bytes_reg;

    logic accept;
    logic front_op_valid;
    op_t  front_op;
    logic opq_empty;
    op_t  head_op;
    logic op_done;

    // Beats with no store effect (stray bytes, zero-length start) are still taken.
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_bytes_reg <= MAX_PACKET_BYTES_RESET;
        end
        else if (cfg_we)
        begin
            max_packet_bytes_reg <= cfg_wdata;
        end
    end

    umep_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .op_valid (front_op_valid),
        .op       (front_op)
    );

    umep_opq u_opq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (accept && front_op_valid),
        .wr_op (front_op),
        .full  (full),
        .rd_en (op_done),
        .empty (opq_empty),
        .rd_op (head_op)
    );

    umep_back #(
        .STORE_BYTES (STORE_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .max_packet_bytes (max_packet_bytes_reg),
        .op_valid         (!opq_empty),
        .op               (head_op),
        .op_done          (op_done),
        .result           (result),
        .empty            (empty),
        .pop              (pop)
    );

endmodule

`default_nettype wire

>>> verif/usb_midi_event_packetizer_tb.sv
// Testbench for the USB-MIDI event packetizer: directed table, random traffic, word scoreboard.
`timescale 1ns / 1ps

module usb_midi_event_packetizer_tb;
    import umep_pkg::*;

    // Store depth in words for the default STORE_BYTES.
    localparam int STORE_WORDS  = (STORE_BYTES_DEFAULT / 4 < MAX_STORE_WORDS) ?
                                  STORE_BYTES_DEFAULT / 4 : MAX_STORE_WORDS;
    // Cycles allowed after the last expected word before the block counts as idle.
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    in_t        item      = '0;
    logic       empty;
    logic       pop       = 1'b0;
    out_t       result;
    logic       cfg_we    = 1'b0;
    logic [6:0] cfg_wdata = 7'd0;

    usb_midi_event_packetizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Packet predictor: own copy of the store, SysEx framing state and
    // the packet size register. Words emitted by one beat land in
    // beat_words, in order.
    // ------------------------------------------------------------------
    logic [31:0] store_mem [STORE_WORDS];
    int unsigned fill_cnt   = 0;
    int unsigned sx_left    = 0;   // framed bytes still due, F7 included
    int unsigned chunk_cnt  = 0;
    logic [23:0] chunk_acc  = '0;
    logic [3:0]  sx_cable   = '0;
    logic [3:0]  last_dev   = '0;
    logic [6:0]  pkt_bytes  = MAX_PACKET_BYTES_RESET;
    out_t        beat_words[$];

    out_t        words_due[$];     // expected words, oldest first
    int          bad_words  = 0;

    // Both sides read no_idle and the result side reads hold_req; the stimulus sets them.
    bit          no_idle    = 1'b0;
    bit          hold_req   = 1'b0;

    // Emit every stored word as one packet, last one marked.
    function automatic void emit_packet(input logic [3:0] dev);
        out_t w;
        for (int i = 0; i < fill_cnt; i++)
        begin
            w.packet_word = store_mem[i];
            w.out_device  = dev;
            w.last_word   = (i + 1 == fill_cnt);
            beat_words.push_back(w);
        end
        fill_cnt = 0;
    endfunction

    // A full store goes out before the new word is written.
    function automatic void place_word(input logic [31:0] word, input logic [3:0] dev);
        if (fill_cnt >= STORE_WORDS)
            emit_packet(dev);
        store_mem[fill_cnt] = word;
        fill_cnt++;
    endfunction

    // Add one framed SysEx byte; a full chunk or the closing chunk becomes a word.
    function automatic void add_sysex_byte(input logic [7:0] b);
        logic [3:0] code;
        chunk_acc = chunk_acc | (24'(b) << (8 * chunk_cnt));
        chunk_cnt++;
        if (sx_left > 0)
            sx_left--;
        if (sx_left == 0)
            code = CIN_SYSEX_CONT + 4'(chunk_cnt);
        else if (chunk_cnt >= 3)
            code = CIN_SYSEX_CONT;
        else
            return;
        place_word({chunk_acc, sx_cable, code}, last_dev);
        chunk_acc = '0;
        chunk_cnt = 0;
    endfunction

    function automatic void predict_beat(input in_t b);
        int unsigned need;
        case (b.cmd)
            CMD_SHORT:
            begin
                last_dev = b.device;
                if (fill_cnt * 4 + 4 >= pkt_bytes)
                    emit_packet(b.device);
                place_word({b.data_second, b.data_first, b.status_byte, b.cable,
                            b.status_byte[7:4]}, b.device);
            end
            CMD_SYSEX_START:
            begin
                // zero length announces nothing
                if (b.sysex_length == 16'd0)
                    return;
                last_dev = b.device;
                need = ((int'(b.sysex_length) + 5) / 4) * 4;
                if (fill_cnt * 4 + need >= pkt_bytes)
                    emit_packet(b.device);
                // an unfinished SysEx and its partial chunk are dropped here
                sx_cable  = b.cable;
                sx_left   = int'(b.sysex_length) + 2;
                chunk_acc = '0;
                chunk_cnt = 0;
                add_sysex_byte(SYSEX_START_BYTE);
            end
            CMD_SYSEX_BYTE:
            begin
                // stray bytes outside a SysEx fall through
                if (sx_left >= 2)
                begin
                    add_sysex_byte(b.payload_byte);
                    if (sx_left == 1)
                        add_sysex_byte(SYSEX_END_BYTE);
                end
            end
            default:
                emit_packet(b.device);
        endcase
    endfunction

    // Scoreboard compare of one popped word against the oldest expectation.
    function automatic void check_word(input out_t got);
        out_t want;
        if (words_due.size() == 0)
        begin
            bad_words++;
            if (bad_words <= 10)
                $display("%0t: unexpected word %h dev %h last %b", $realtime,
                         got.packet_word, got.out_device, got.last_word);
            return;
        end
        want = words_due.pop_front();
        if (got.packet_word !== want.packet_word || got.out_device !== want.out_device ||
            got.last_word !== want.last_word)
        begin
            bad_words++;
            if (bad_words <= 10)
                $display("%0t: word mismatch: expected %h dev %h last %b, got %h dev %h last %b",
                         $realtime, want.packet_word, want.out_device, want.last_word,
                         got.packet_word, got.out_device, got.last_word);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: per-cycle pop control. A random stall is drawn after
    // every popped word; a hold request keeps pop low for a long run
    // so the store and op queue back up and full rises.
    // ------------------------------------------------------------------
    initial
    begin : result_side
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                check_word(result);
                stall_left = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one beat after a random gap; predict once it is taken.
    // A typed-in word replaces the predicted ones where given.
    task automatic send_beat(input in_t b, input bit has_lit = 1'b0, input out_t lit = '0);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= b;
        do @(posedge clk); while (full);
        beat_words.delete();
        predict_beat(b);
        if (has_lit)
            words_due.push_back(lit);
        else
            foreach (beat_words[i])
                words_due.push_back(beat_words[i]);
    endtask

    // Wait until every expected word is out, then let beats without
    // results finish inside the block.
    task automatic wait_drained();
        push <= 1'b0;
        while (words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_packet_size(input logic [6:0] bytes);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= bytes;
        @(posedge clk);
        cfg_we    <= 1'b0;
        pkt_bytes = bytes;
    endtask

    function automatic in_t rand_beat(input cmd_t c);
        logic [63:0] r;
        in_t         b;
        r = {$urandom, $urandom};
        b = r[$bits(in_t)-1:0];
        b.cmd = c;
        return b;
    endfunction

    // Mostly well-formed SysEx and short messages with random content,
    // plus cut-off SysEx, huge announced lengths, flushes and noise.
    task automatic random_traffic(input int budget);
        int   sent;
        int   pick;
        int   len;
        int   cut;
        in_t  b;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                send_beat(rand_beat(CMD_SHORT));
                sent++;
            end
            else if (pick < 75)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(21, 70) :
                                                     $urandom_range(1, 20);
                b = rand_beat(CMD_SYSEX_START);
                b.sysex_length = 16'(len);
                send_beat(b);
                sent++;
                cut = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : len;
                for (int k = 0; k < cut; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        send_beat(rand_beat(CMD_SHORT));
                        sent++;
                    end
                    send_beat(rand_beat(CMD_SYSEX_BYTE));
                    sent++;
                end
            end
            else if (pick < 85)
            begin
                send_beat(rand_beat(CMD_FLUSH));
                sent++;
            end
            else if (pick < 92)
            begin
                // noise: zero-length start or a byte that may be stray
                if ($urandom_range(0, 1) == 0)
                begin
                    b = rand_beat(CMD_SYSEX_START);
                    b.sysex_length = 16'd0;
                    send_beat(b);
                end
                else
                    send_beat(rand_beat(CMD_SYSEX_BYTE));
            end
            else
            begin
                // any announced length, only a few bytes follow
                b = rand_beat(CMD_SYSEX_START);
                b.sysex_length = 16'($urandom_range(0, 65535));
                send_beat(b);
                sent++;
                repeat ($urandom_range(0, 5))
                begin
                    send_beat(rand_beat(CMD_SYSEX_BYTE));
                    sent++;
                end
            end
        end
    endtask

    // Directed table: one row per beat, a typed-in word where obvious.
    typedef struct {
        in_t  beat;
        bit   has_lit;
        out_t lit;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void add_row(input cmd_t c, input logic [3:0] dev,
                                    input logic [3:0] cab, input logic [7:0] st,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [15:0] len, input logic [7:0] pb,
                                    input bit has_lit = 1'b0, input logic [31:0] w = '0);
        dir_row_t r;
        r.beat.cmd          = c;
        r.beat.device       = dev;
        r.beat.cable        = cab;
        r.beat.status_byte  = st;
        r.beat.data_first   = d1;
        r.beat.data_second  = d2;
        r.beat.sysex_length = len;
        r.beat.payload_byte = pb;
        r.has_lit           = has_lit;
        r.lit.packet_word   = w;
        r.lit.out_device    = dev;
        r.lit.last_word     = 1'b1;
        dir_rows.push_back(r);
    endfunction

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[usb_midi_event_packetizer] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [6:0] sizes [5];
        in_t        b;

        // short messages, one at a time through a flush
        add_row(CMD_SHORT,       4'h3, 4'h0, 8'h90, 8'h3C, 8'h7F, 16'd0,     8'h00);
        add_row(CMD_FLUSH,       4'h5, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00,
                1'b1, 32'h7F3C_9009);
        add_row(CMD_SHORT,       4'hF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 16'd0,     8'h00);
        add_row(CMD_FLUSH,       4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00,
                1'b1, 32'hFFFF_FFFF);
        add_row(CMD_SHORT,       4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00);
        add_row(CMD_FLUSH,       4'hF, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00,
                1'b1, 32'h0000_0000);
        // flush with nothing stored, stray payload byte, zero-length SysEx
        add_row(CMD_FLUSH,       4'h9, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h0, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h12);
        add_row(CMD_SYSEX_START, 4'h4, 4'h2, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00);
        // one-byte SysEx: F0 00 F7 in a single end-of-three word
        add_row(CMD_SYSEX_START, 4'h4, 4'h2, 8'h00, 8'h00, 8'h00, 16'd1,     8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h4, 4'h2, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00);
        add_row(CMD_FLUSH,       4'h4, 4'h1, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00,
                1'b1, 32'hF700_F027);
        // short message in the middle of a chunk, then restart over a
        // partial chunk with the longest length, then another restart
        add_row(CMD_SYSEX_START, 4'h1, 4'h1, 8'h00, 8'h00, 8'h00, 16'd4,     8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h1, 4'h1, 8'h00, 8'h00, 8'h00, 16'd0,     8'hFF);
        add_row(CMD_SHORT,       4'h7, 4'hE, 8'hC5, 8'h11, 8'h00, 16'd0,     8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h1, 4'h1, 8'h00, 8'h00, 8'h00, 16'd0,     8'h80);
        add_row(CMD_SYSEX_BYTE,  4'h1, 4'h1, 8'h00, 8'h00, 8'h00, 16'd0,     8'h7E);
        add_row(CMD_SYSEX_START, 4'h2, 4'h3, 8'h00, 8'h00, 8'h00, 16'hFFFF,  8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h2, 4'h3, 8'h00, 8'h00, 8'h00, 16'd0,     8'h55);
        // two-byte SysEx ends with a one-byte chunk
        add_row(CMD_SYSEX_START, 4'h6, 4'hF, 8'h00, 8'h00, 8'h00, 16'd2,     8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h6, 4'hF, 8'h00, 8'h00, 8'h00, 16'd0,     8'h7F);
        add_row(CMD_SYSEX_BYTE,  4'h6, 4'hF, 8'h00, 8'h00, 8'h00, 16'd0,     8'h01);
        // three-byte SysEx ends with a two-byte chunk
        add_row(CMD_SYSEX_START, 4'h8, 4'h0, 8'h00, 8'h00, 8'h00, 16'd3,     8'h00);
        add_row(CMD_SYSEX_BYTE,  4'h8, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'hAA);
        add_row(CMD_SYSEX_BYTE,  4'h8, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h55);
        add_row(CMD_SYSEX_BYTE,  4'h8, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'hFF);
        add_row(CMD_FLUSH,       4'hA, 4'h0, 8'h00, 8'h00, 8'h00, 16'd0,     8'h00);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part runs at the reset packet size.
        foreach (dir_rows[i])
            send_beat(dir_rows[i].beat, dir_rows[i].has_lit, dir_rows[i].lit);

        // Random part over several packet sizes, smallest and near-largest among them.
        sizes = '{7'd4, 7'd63, 7'd8, 7'd37, 7'd17};
        foreach (sizes[p])
        begin
            set_packet_size(sizes[p]);
            no_idle = (sizes[p] == 7'd37);
            random_traffic(20);
        end
        no_idle = 1'b0;

        // Back-pressure: receiver holds off while short messages keep coming.
        set_packet_size(7'd64);
        hold_req = 1'b1;
        no_idle  = 1'b1;
        repeat (60)
            send_beat(rand_beat(CMD_SHORT));
        no_idle = 1'b0;
        b = rand_beat(CMD_FLUSH);
        send_beat(b);

        wait_drained();
        repeat (30) @(posedge clk);
        if (bad_words == 0 && words_due.size() == 0)
            $display("[usb_midi_event_packetizer] OK");
        else
            $display("[usb_midi_event_packetizer] ERROR");
        $finish;
    end

endmodule
